FILE: design/assert_macros.svh
// Concurrent assertion helpers. Both forms take the clock and the active-low
// reset and check only while the block is out of reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/clle_pkg.sv
package clle_pkg;

    localparam int LINES_DEF = 32;

    localparam int KIND_W = 3;
    localparam int LINE_W = 16;
    localparam int AMT_W  = 8;
    localparam int RK_W   = 3;

    // operation codes
    localparam logic [KIND_W-1:0] K_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] K_DELETE   = 3'd1;
    localparam logic [KIND_W-1:0] K_MOVE     = 3'd2;
    localparam logic [KIND_W-1:0] K_LIST_CUR = 3'd3;
    localparam logic [KIND_W-1:0] K_LIST_ALL = 3'd4;

    // result codes
    localparam logic [RK_W-1:0] RK_LINE    = 3'd0;
    localparam logic [RK_W-1:0] RK_END     = 3'd1;
    localparam logic [RK_W-1:0] RK_DELETED = 3'd2;
    localparam logic [RK_W-1:0] RK_NOTHING = 3'd3;
    localparam logic [RK_W-1:0] RK_FULL    = 3'd4;

    // walk index operations
    localparam int IDX_OP_W = 3;
    localparam logic [IDX_OP_W-1:0] IDX_HOLD      = 3'd0;
    localparam logic [IDX_OP_W-1:0] IDX_LD_COUNT  = 3'd1;
    localparam logic [IDX_OP_W-1:0] IDX_LD_CURSOR = 3'd2;
    localparam logic [IDX_OP_W-1:0] IDX_LD_ZERO   = 3'd3;
    localparam logic [IDX_OP_W-1:0] IDX_DEC       = 3'd4;
    localparam logic [IDX_OP_W-1:0] IDX_INC       = 3'd5;

    // read address selects
    localparam int RD_SEL_W = 2;
    localparam logic [RD_SEL_W-1:0] RD_IDX_M1 = 2'd0;
    localparam logic [RD_SEL_W-1:0] RD_IDX_P1 = 2'd1;
    localparam logic [RD_SEL_W-1:0] RD_IDX    = 2'd2;
    localparam logic [RD_SEL_W-1:0] RD_MOVE   = 2'd3;

    // count and cursor updates
    localparam int CC_OP_W = 2;
    localparam logic [CC_OP_W-1:0] CC_HOLD   = 2'd0;
    localparam logic [CC_OP_W-1:0] CC_INSERT = 2'd1;
    localparam logic [CC_OP_W-1:0] CC_DELETE = 2'd2;
    localparam logic [CC_OP_W-1:0] CC_MOVE   = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [LINE_W-1:0]        line_value;
        logic signed [AMT_W-1:0]  move_amount;
    } item_t;

    typedef struct packed {
        logic [RK_W-1:0]   result_kind;
        logic [LINE_W-1:0] line_out;
        logic              last;
    } result_t;

    typedef struct packed {
        logic                 load_item;
        logic [IDX_OP_W-1:0]  idx_op;
        logic                 rd_en;
        logic [RD_SEL_W-1:0]  rd_sel;
        logic                 shift_wb;
        logic                 wr_value;
        logic [CC_OP_W-1:0]   cc_op;
        logic                 emit;
        logic [RK_W-1:0]      emit_kind;
        logic                 list_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] item_kind;
        logic              full;
        logic              cur_at_end;
        logic              ins_done;
        logic              del_done;
        logic              list_done;
    } dp_status_t;

endpackage

FILE: design/clle_datapath.sv
module clle_datapath
    import clle_pkg::*;
#(
    parameter int LINES = LINES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       result_valid,
    output result_t    result
);

    localparam int IDX_W  = $clog2(LINES + 1);
    localparam int ADDR_W = $clog2(LINES);
    localparam int SUM_W  = ((IDX_W > AMT_W) ? IDX_W : AMT_W) + 2;

    item_t             item_reg;
    logic [IDX_W-1:0]  count_reg,  count_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic              pend_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic [LINE_W-1:0] rd_data_reg;
    logic [LINE_W-1:0] line_store_reg [LINES];
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    logic signed [SUM_W-1:0] move_sum;
    logic signed [SUM_W-1:0] count_ext;
    logic [IDX_W-1:0]        move_tgt;
    logic [IDX_W-1:0]        rd_idx;
    logic                    rd_ok;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [LINE_W-1:0]       wr_data;

    // clamp cursor plus step to the head and the end
    always_comb
    begin
        move_sum  = $signed({{(SUM_W-IDX_W){1'b0}}, cursor_reg})
                  + $signed({{(SUM_W-AMT_W){item_reg.move_amount[AMT_W-1]}},
                             item_reg.move_amount});
        count_ext = $signed({{(SUM_W-IDX_W){1'b0}}, count_reg});
        if (move_sum < 0)
        begin
            move_tgt = '0;
        end
        else if (move_sum > count_ext)
        begin
            move_tgt = count_reg;
        end
        else
        begin
            move_tgt = move_sum[IDX_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX_M1: rd_idx = idx_reg - IDX_W'(1);
            RD_IDX_P1: rd_idx = idx_reg + IDX_W'(1);
            RD_IDX:    rd_idx = idx_reg;
            RD_MOVE:   rd_idx = move_tgt;
            default:   rd_idx = idx_reg;
        endcase
        rd_ok   = cmd.rd_en && (rd_idx < count_reg);
        rd_addr = rd_idx[ADDR_W-1:0];
    end

    // one write port: shifted entry write-back or the new line
    always_comb
    begin
        wr_en   = cmd.wr_value || (cmd.shift_wb && pend_reg);
        wr_addr = cmd.wr_value ? cursor_reg[ADDR_W-1:0] : wb_addr_reg;
        wr_data = cmd.wr_value ? item_reg.line_value : rd_data_reg;
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD:      idx_next = idx_reg;
            IDX_LD_COUNT:  idx_next = count_reg;
            IDX_LD_CURSOR: idx_next = cursor_reg;
            IDX_LD_ZERO:   idx_next = '0;
            IDX_DEC:       idx_next = idx_reg - IDX_W'(1);
            IDX_INC:       idx_next = idx_reg + IDX_W'(1);
            default:       idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        case (cmd.cc_op)
            CC_HOLD:
            begin
                count_next = count_reg;
            end
            CC_INSERT:
            begin
                count_next  = count_reg + IDX_W'(1);
                cursor_next = cursor_reg + IDX_W'(1);
            end
            CC_DELETE:
            begin
                count_next = count_reg - IDX_W'(1);
            end
            CC_MOVE:
            begin
                cursor_next = move_tgt;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = '0;
        if (cmd.list_emit && pend_reg)
        begin
            result_valid_next       = 1'b1;
            result_next.result_kind = RK_LINE;
            result_next.line_out    = rd_data_reg;
            result_next.last        = 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_next       = 1'b1;
            result_next.result_kind = cmd.emit_kind;
            result_next.line_out    = (cmd.emit_kind == RK_LINE) ? rd_data_reg : '0;
            result_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            cursor_reg       <= '0;
            idx_reg          <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            cursor_reg       <= cursor_next;
            idx_reg          <= idx_next;
            pend_reg         <= rd_ok;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (rd_ok)
        begin
            wb_addr_reg <= idx_reg[ADDR_W-1:0];
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_store_reg[wr_addr] <= wr_data;
        end
        if (rd_ok)
        begin
            rd_data_reg <= line_store_reg[rd_addr];
        end
    end

    always_comb
    begin
        status.item_kind  = item_reg.kind;
        status.full       = (count_reg >= IDX_W'(LINES));
        status.cur_at_end = (cursor_reg >= count_reg);
        status.ins_done   = (idx_reg <= cursor_reg);
        status.del_done   = (({1'b0, idx_reg} + (IDX_W+1)'(1)) >= {1'b0, count_reg});
        status.list_done  = (idx_reg >= count_reg);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: design/clle_ctrl.sv
module clle_ctrl
    import clle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_IDLE      = 4'd0;
    localparam logic [ST_W-1:0] S_DECODE    = 4'd1;
    localparam logic [ST_W-1:0] S_INS_SHIFT = 4'd2;
    localparam logic [ST_W-1:0] S_INS_WRITE = 4'd3;
    localparam logic [ST_W-1:0] S_DEL_SHIFT = 4'd4;
    localparam logic [ST_W-1:0] S_DEL_DONE  = 4'd5;
    localparam logic [ST_W-1:0] S_MOVE_OUT  = 4'd6;
    localparam logic [ST_W-1:0] S_LIST      = 4'd7;
    localparam logic [ST_W-1:0] S_LIST_END  = 4'd8;

    logic [ST_W-1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (status.item_kind)
                    K_INSERT:
                    begin
                        if (status.full)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = RK_FULL;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_LD_COUNT;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    K_DELETE:
                    begin
                        if (status.cur_at_end)
                        begin
                            cmd.emit      = 1'b1;
                            cmd.emit_kind = RK_NOTHING;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_LD_CURSOR;
                            state_next = S_DEL_SHIFT;
                        end
                    end
                    K_MOVE:
                    begin
                        cmd.cc_op  = CC_MOVE;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_MOVE;
                        state_next = S_MOVE_OUT;
                    end
                    K_LIST_CUR:
                    begin
                        cmd.idx_op = IDX_LD_CURSOR;
                        state_next = S_LIST;
                    end
                    K_LIST_ALL:
                    begin
                        cmd.idx_op = IDX_LD_ZERO;
                        state_next = S_LIST;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INS_SHIFT:
            begin
                // walk down from the end, one entry up per cycle
                cmd.shift_wb = 1'b1;
                if (status.ins_done)
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_M1;
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_INS_WRITE:
            begin
                cmd.wr_value = 1'b1;
                cmd.cc_op    = CC_INSERT;
                state_next   = S_IDLE;
            end
            S_DEL_SHIFT:
            begin
                // walk up from the cursor, one entry down per cycle
                cmd.shift_wb = 1'b1;
                if (status.del_done)
                begin
                    state_next = S_DEL_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX_P1;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_DEL_DONE:
            begin
                cmd.cc_op     = CC_DELETE;
                cmd.emit      = 1'b1;
                cmd.emit_kind = RK_DELETED;
                state_next    = S_IDLE;
            end
            S_MOVE_OUT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = status.cur_at_end ? RK_END : RK_LINE;
                state_next    = S_IDLE;
            end
            S_LIST:
            begin
                cmd.list_emit = 1'b1;
                if (status.list_done)
                begin
                    state_next = S_LIST_END;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_LIST_END:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_kind = RK_END;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/cursor_line_list_engine_core.sv
// Channel   Beat marked by          Payload          Direction
// -------   ---------------------   --------------   ---------
// command   start && !busy          item (item_t)    in
// result    result_valid            result (result_t) out
//
// An item is latched on acceptance, then decoded. An insert shifts the entries from
//   the cursor up by one and writes the new line, a delete shifts those above the
//   cursor down by one, a move reads the line at the new cursor, and a listing reads
//   each listed line and then the end marker; one entry is read, one written per cycle.
// Each result beat shows on the cycle after the engine produces it; the receiver
// cannot stall, so results are never held. Reset empties the list and puts the
// cursor at the end; the line store itself is not cleared.
`include "assert_macros.svh"

module cursor_line_list_engine_core
    import clle_pkg::*;
#(
    parameter int LINES = LINES_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    result_valid,
    output result_t result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer: decodes the latched beat and steps the walk over the store.
    clle_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath: line store, count, cursor, walk index and the result register.
    clle_datapath #(
        .LINES (LINES)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

    // A new command never produces a result in the very next cycle.
    `ASSERT_NEXT(a_no_instant_result, clk, rst_n, start && !busy, !result_valid, "result right after accept")

    // The closing beat of a command leaves the engine ready for the next one.
    `ASSERT_IMPLIES(a_last_frees_engine, clk, rst_n, result_valid && result.last, !busy, "busy after last beat")

    // Only listed lines come without the last flag.
    `ASSERT_IMPLIES(a_mid_is_line, clk, rst_n, result_valid && !result.last, result.result_kind == RK_LINE, "non-line mid beat")

    // Non-line results carry a zero handle.
    `ASSERT_IMPLIES(a_zero_handle, clk, rst_n, result_valid && (result.result_kind != RK_LINE), result.line_out == '0, "handle on non-line beat")

endmodule

FILE: test/cursor_line_list_engine_core_tb.sv
module cursor_line_list_engine_core_tb;
    import clle_pkg::*;

    // Kind codes the engine has no operation for; it must drop them silently.
    localparam logic [KIND_W-1:0] K_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_LAST  = 3'd7;

    localparam int LINES          = LINES_DEF;
    // Longest item is a full shift or a full listing.
    localparam int SETTLE_CYCLES  = LINES + 8;
    localparam int WATCHDOG_LIMIT = 1000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   cmd;
    logic    result_valid;
    result_t rsp;

    cursor_line_list_engine_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (cmd),
        .result_valid (result_valid),
        .result       (rsp)
    );

    // Shadow copy of the list: the lines in order, head at entry 0,
    // plus the line count and the cursor (count means end of list).
    logic [LINE_W-1:0] shadow_lines [LINES];
    int                shadow_count;
    int                shadow_cursor;

    // Result beats still owed by the engine, oldest first.
    result_t pending_results [$];
    result_t want_beat;

    int err_count;
    int cmds_sent;
    int beats_seen;
    int full_seen;
    int nothing_seen;
    int max_list_beats;
    int list_beats;
    int quiet_cycles;
    int idle_pct;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    function automatic void owe_beat(input logic [RK_W-1:0] kind,
                                     input logic [LINE_W-1:0] line, input logic last);
        result_t beat;
        beat.result_kind = kind;
        beat.line_out    = line;
        beat.last        = last;
        pending_results.push_back(beat);
    endfunction

    // Queue every line from position first to the end, then the end marker.
    function automatic void owe_listing(input int first);
        for (int i = first; i < shadow_count; i++)
            owe_beat(RK_LINE, shadow_lines[i], 1'b0);
        owe_beat(RK_END, '0, 1'b1);
    endfunction

    // Apply one accepted command to the shadow list and queue its result beats.
    function automatic void apply_list_cmd(input item_t it);
        int pos;
        case (it.kind)
            K_INSERT:
            begin
                if (shadow_count >= LINES)
                    owe_beat(RK_FULL, '0, 1'b1);
                else
                begin
                    for (int i = shadow_count; i > shadow_cursor; i--)
                        shadow_lines[i] = shadow_lines[i-1];
                    shadow_lines[shadow_cursor] = it.line_value;
                    shadow_count++;
                    shadow_cursor++;
                end
            end
            K_DELETE:
            begin
                if (shadow_cursor >= shadow_count)
                    owe_beat(RK_NOTHING, '0, 1'b1);
                else
                begin
                    for (int i = shadow_cursor; i + 1 < shadow_count; i++)
                        shadow_lines[i] = shadow_lines[i+1];
                    shadow_count--;
                    owe_beat(RK_DELETED, '0, 1'b1);
                end
            end
            K_MOVE:
            begin
                pos = shadow_cursor + int'(it.move_amount);
                if (pos < 0)
                    pos = 0;
                if (pos > shadow_count)
                    pos = shadow_count;
                shadow_cursor = pos;
                if (shadow_cursor < shadow_count)
                    owe_beat(RK_LINE, shadow_lines[shadow_cursor], 1'b1);
                else
                    owe_beat(RK_END, '0, 1'b1);
            end
            K_LIST_CUR:
                owe_listing(shadow_cursor);
            K_LIST_ALL:
                owe_listing(0);
            default:
            begin
            end
        endcase
    endfunction

    function automatic item_t make_cmd(input logic [KIND_W-1:0] kind,
                                       input logic [LINE_W-1:0] value,
                                       input logic [AMT_W-1:0] amount);
        item_t it;
        it.kind        = kind;
        it.line_value  = value;
        it.move_amount = amount;
        return it;
    endfunction

    // Send one command beat. Called and returning at a falling edge; start is
    // left high so that a following command can go out back to back.
    task automatic send_cmd(input item_t it);
        // Idle the command channel at random; scramble the payload meanwhile
        // to show it is ignored while start is low.
        while ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            cmd   = item_t'($urandom);
            @(negedge clk);
        end
        start = 1'b1;
        cmd   = it;
        // Hold the beat until the engine takes it.
        do
            @(posedge clk);
        while (busy);
        apply_list_cmd(it);
        cmds_sent++;
        @(negedge clk);
    endtask

    // Drop start and wait until every owed result has arrived, then give a
    // trailing insert (which owes nothing) time to finish its shift.
    task automatic wait_engine_idle();
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly small cursor steps, with the odd extreme or fully random jump.
    function automatic logic [AMT_W-1:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return AMT_W'($urandom_range(6) - 3);
        else if (r < 80)
            return 8'h80;
        else if (r < 90)
            return 8'h7F;
        else
            return AMT_W'($urandom);
    endfunction

    // Empty-list corners, head and end clamping, extreme handles and spare kinds.
    task automatic test_directed();
        send_cmd(make_cmd(K_DELETE,   16'h1234, 8'h00));
        send_cmd(make_cmd(K_MOVE,     16'h0000, 8'h00));
        send_cmd(make_cmd(K_LIST_CUR, 16'hFFFF, 8'hFF));
        send_cmd(make_cmd(K_LIST_ALL, 16'h0000, 8'h80));
        send_cmd(make_cmd(K_INSERT,   16'h0000, 8'h7F));
        send_cmd(make_cmd(K_INSERT,   16'hFFFF, 8'h80));
        send_cmd(make_cmd(K_INSERT,   16'h8001, 8'h00));
        send_cmd(make_cmd(K_MOVE,     16'hFFFF, 8'h80));
        // Insert before the head; the cursor must stay on the old head.
        send_cmd(make_cmd(K_INSERT,   16'h7FFE, 8'h01));
        send_cmd(make_cmd(K_LIST_CUR, 16'h0000, 8'h00));
        send_cmd(make_cmd(K_MOVE,     16'h0000, 8'h7F));
        send_cmd(make_cmd(K_MOVE,     16'h0000, 8'hFF));
        send_cmd(make_cmd(K_LIST_ALL, 16'h0000, 8'h00));
        // Delete the tail, then try again at the end.
        send_cmd(make_cmd(K_DELETE,   16'h0000, 8'h00));
        send_cmd(make_cmd(K_DELETE,   16'hFFFF, 8'h7F));
        send_cmd(make_cmd(K_MOVE,     16'h0000, 8'hFE));
        send_cmd(make_cmd(K_DELETE,   16'h0000, 8'h00));
        send_cmd(make_cmd(K_MOVE,     16'h0000, 8'h80));
        send_cmd(make_cmd(K_DELETE,   16'h0000, 8'h00));
        send_cmd(make_cmd(K_SPARE_FIRST, 16'hFFFF, 8'h80));
        send_cmd(make_cmd(K_SPARE_FIRST + 3'd1, 16'h0000, 8'h7F));
        send_cmd(make_cmd(K_SPARE_LAST, 16'hA5A5, 8'hFF));
        send_cmd(make_cmd(K_LIST_ALL, 16'h0000, 8'h00));
        send_cmd(make_cmd(K_LIST_CUR, 16'h0000, 8'h00));
    endtask

    // Fill the list to capacity at wandering cursor positions, push past full,
    // list the whole thing, then empty it again.
    task automatic test_full_list();
        while (shadow_count < LINES)
        begin
            if ($urandom_range(3) == 0)
                send_cmd(make_cmd(K_MOVE, '0, pick_step()));
            send_cmd(make_cmd(K_INSERT, LINE_W'($urandom), AMT_W'($urandom)));
        end
        send_cmd(make_cmd(K_INSERT, LINE_W'($urandom), AMT_W'($urandom)));
        send_cmd(make_cmd(K_INSERT, 16'hFFFF, 8'h80));
        send_cmd(make_cmd(K_LIST_ALL, '0, '0));
        send_cmd(make_cmd(K_MOVE, '0, 8'h80));
        send_cmd(make_cmd(K_LIST_CUR, '0, '0));
        send_cmd(make_cmd(K_MOVE, '0, 8'h7F));
        send_cmd(make_cmd(K_LIST_CUR, '0, '0));
        send_cmd(make_cmd(K_MOVE, '0, AMT_W'(-LINES / 2)));
        send_cmd(make_cmd(K_LIST_CUR, '0, '0));
        while (shadow_count > 0)
        begin
            if (shadow_cursor >= shadow_count || $urandom_range(3) == 0)
                send_cmd(make_cmd(K_MOVE, '0, pick_step()));
            send_cmd(make_cmd(K_DELETE, LINE_W'($urandom), AMT_W'($urandom)));
        end
        send_cmd(make_cmd(K_DELETE, '0, '0));
        send_cmd(make_cmd(K_LIST_ALL, '0, '0));
    endtask

    // Random command mix; ins_pct steers the list toward full or empty.
    // Spare kinds are sent too but not counted.
    task automatic test_random_ops(input int n_cmds, input int ins_pct);
        int done;
        int r;
        logic [KIND_W-1:0] kind;
        done = 0;
        while (done < n_cmds)
        begin
            r = $urandom_range(99);
            if (r < ins_pct)
                kind = K_INSERT;
            else if (r < ins_pct + (100 - ins_pct) * 35 / 100)
                kind = K_DELETE;
            else if (r < ins_pct + (100 - ins_pct) * 75 / 100)
                kind = K_MOVE;
            else if (r < ins_pct + (100 - ins_pct) * 86 / 100)
                kind = K_LIST_CUR;
            else if (r < ins_pct + (100 - ins_pct) * 96 / 100)
                kind = K_LIST_ALL;
            else
                kind = KIND_W'($urandom_range(K_SPARE_FIRST, K_SPARE_LAST));
            send_cmd(make_cmd(kind, LINE_W'($urandom),
                              (kind == K_MOVE) ? pick_step() : AMT_W'($urandom)));
            if (kind < K_SPARE_FIRST)
                done++;
        end
    endtask

    // Compare every result beat against the oldest owed beat, field by field.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing owed", 32'(rsp), '0);
            else
            begin
                want_beat = pending_results.pop_front();
                if (rsp.result_kind !== want_beat.result_kind)
                    report_mismatch("result_kind", 32'(rsp.result_kind),
                                    32'(want_beat.result_kind));
                if (rsp.line_out !== want_beat.line_out)
                    report_mismatch("line_out", 32'(rsp.line_out), 32'(want_beat.line_out));
                if (rsp.last !== want_beat.last)
                    report_mismatch("last", 32'(rsp.last), 32'(want_beat.last));
                if (want_beat.result_kind == RK_FULL)
                    full_seen++;
                if (want_beat.result_kind == RK_NOTHING)
                    nothing_seen++;
                // Track the longest listing seen.
                list_beats = want_beat.last ? 0 : list_beats + 1;
                if (list_beats + 1 > max_list_beats)
                    max_list_beats = list_beats + 1;
            end
        end
    end

    // End the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TIMEOUT: no beat for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        cmd            = '0;
        err_count      = 0;
        cmds_sent      = 0;
        beats_seen     = 0;
        full_seen      = 0;
        nothing_seen   = 0;
        max_list_beats = 0;
        list_beats     = 0;
        idle_pct       = 0;
        shadow_count   = 0;
        shadow_cursor  = 0;

        // Hold reset, then release it between edges.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        wait_engine_idle();

        test_full_list();
        wait_engine_idle();

        // Sender idles about half the time; list drifts toward full.
        idle_pct = 51;
        test_random_ops(100, 45);
        wait_engine_idle();

        idle_pct = 18;
        test_random_ops(100, 25);
        wait_engine_idle();

        // Back-to-back commands, balanced mix.
        idle_pct = 0;
        test_random_ops(70, 35);
        wait_engine_idle();

        if (pending_results.size() != 0)
            report_mismatch("result beats never delivered", '0, 32'(pending_results.size()));

        $display("Covered %0d commands and %0d result beats, longest listing %0d beats.",
                 cmds_sent, beats_seen, max_list_beats);
        $display("Saw %0d list-full and %0d nothing-to-delete responses.",
                 full_seen, nothing_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/clle_pkg.sv
design/clle_datapath.sv
design/clle_ctrl.sv
design/cursor_line_list_engine_core.sv
test/cursor_line_list_engine_core_tb.sv
